>>> src/foc_current_loop_top_assert.svh
// Assertion macros for the field-oriented current loop.
`ifndef FOC_CURRENT_LOOP_TOP_ASSERT_SVH
`define FOC_CURRENT_LOOP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define FOC_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("foc_current_loop_top: assertion failed");
`define FOC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("foc_current_loop_top: assertion failed");
`else
`define FOC_ASSERT_IMP(lbl, pre, post)
`define FOC_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

>>> src/foc_cl_pkg.sv
// Shared types, constants and functions of the field-oriented current loop.
package foc_cl_pkg;

  localparam int SINE_ENTRIES_DEF = 256;
  localparam int PWM_MIDPOINT_DEF = 512;
  localparam int ADC_BITS_DEF     = 12;

  // serial multiplier: data operand, coefficient operand, accumulator
  localparam int MA_W   = 24;
  localparam int MB_W   = 17;
  localparam int ACC_W  = 40;
  localparam int MCNT_W = $clog2(MB_W);

  // serial divider: dividend and divisor widths
  localparam int DIV_W  = 22;
  localparam int DVS_W  = 11;
  localparam int DCNT_W = $clog2(DIV_W);

  localparam logic signed [MB_W-1:0] K_INV_SQRT6 = 17'sd6689;
  localparam logic signed [MB_W-1:0] K_INV_SQRT2 = 17'sd11585;
  localparam logic signed [MB_W-1:0] K_SQRT_2_3  = 17'sd13377;
  localparam logic [DVS_W-1:0]       SMOOTH_DIV  = 11'd20;

  localparam logic [15:0] CURRENT_SCALE_RST = 16'd410;
  localparam logic [15:0] PROP_GAIN_RST     = 16'd40960;
  localparam logic [15:0] INTEG_GAIN_RST    = 16'd1147;
  localparam logic [9:0]  INTEG_LIMIT_RST   = 10'd200;
  localparam logic [11:0] CURRENT_TRIP_RST  = 12'd4095;
  localparam logic [11:0] VOLTAGE_TRIP_RST  = 12'd4095;
  localparam logic [11:0] INIT_CYCLES_RST   = 12'd1000;
  localparam logic [11:0] ADC_OFFSET_RST    = 12'd1900;

  typedef enum logic [2:0] {
    REG_CURRENT_SCALE = 3'd0,
    REG_PROP_GAIN     = 3'd1,
    REG_INTEG_GAIN    = 3'd2,
    REG_INTEG_LIMIT   = 3'd3,
    REG_CURRENT_TRIP  = 3'd4,
    REG_VOLTAGE_TRIP  = 3'd5,
    REG_INIT_CYCLES   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic start;
    logic clear;
    logic sub;
  } mul_ctl_t;

  localparam logic [14:0] QSINE [65] = '{
    15'd0, 15'd402, 15'd804, 15'd1205, 15'd1606, 15'd2006, 15'd2404, 15'd2801,
    15'd3196, 15'd3590, 15'd3981, 15'd4370, 15'd4756, 15'd5139, 15'd5520,
    15'd5897, 15'd6270, 15'd6639, 15'd7005, 15'd7366, 15'd7723, 15'd8076,
    15'd8423, 15'd8765, 15'd9102, 15'd9434, 15'd9760, 15'd10080, 15'd10394,
    15'd10702, 15'd11003, 15'd11297, 15'd11585, 15'd11866, 15'd12140,
    15'd12406, 15'd12665, 15'd12916, 15'd13160, 15'd13395, 15'd13623,
    15'd13842, 15'd14053, 15'd14256, 15'd14449, 15'd14635, 15'd14811,
    15'd14978, 15'd15137, 15'd15286, 15'd15426, 15'd15557, 15'd15679,
    15'd15791, 15'd15893, 15'd15986, 15'd16069, 15'd16143, 15'd16207,
    15'd16261, 15'd16305, 15'd16340, 15'd16364, 15'd16379, 15'd16384
  };

  // Q1.14 sine of p/256 turn, folded from the quarter wave
  function automatic logic signed [15:0] sine_lut(input logic [7:0] p);
    logic [6:0]  r;
    logic [14:0] m;
    r = {1'b0, p[5:0]};
    m = 15'd0;
    case (p[7:6])
      2'd0: m = QSINE[r];
      2'd1: m = QSINE[7'd64 - r];
      2'd2: m = QSINE[r];
      default: m = QSINE[7'd64 - r];
    endcase
    return p[7] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // round half up, then arithmetic shift right by n
  function automatic logic signed [ACC_W-1:0] rnd_sh(input logic signed [ACC_W-1:0] v,
                                                      input int unsigned n);
    logic signed [ACC_W-1:0] h;
    logic signed [ACC_W-1:0] t;
    h = ACC_W'(1) << (n - 1);
    t = v + h;
    return t >>> n;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v > 40'sd32767) begin
      return 16'sh7fff;
    end else if (v < -40'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] clamp40(input logic signed [ACC_W-1:0] v,
                                                       input logic signed [ACC_W-1:0] lo,
                                                       input logic signed [ACC_W-1:0] hi);
    if (v < lo) begin
      return lo;
    end else if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

endpackage

>>> src/foc_cl_mul.sv
// Bit-serial signed multiply-accumulate unit, one coefficient bit per cycle.
module foc_cl_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  foc_cl_pkg::mul_ctl_t               ctl,
  input  logic signed [foc_cl_pkg::MA_W-1:0] a,
  input  logic signed [foc_cl_pkg::MB_W-1:0] b,
  output logic signed [foc_cl_pkg::ACC_W-1:0] acc,
  output logic                               done
);
  import foc_cl_pkg::*;

  logic signed [ACC_W-1:0] a_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] acc_nxt;
  logic signed [ACC_W-1:0] term;
  logic [MB_W-1:0]         b_r;
  logic [MCNT_W-1:0]       cnt_r;
  logic                    busy_r;
  logic                    sub_r;
  logic                    done_r;
  logic                    neg;
  logic                    last;

  assign last = (cnt_r == MCNT_W'(MB_W - 1));

  always_comb begin
    // the top coefficient bit carries negative weight
    neg     = last ^ sub_r;
    term    = b_r[0] ? a_r : '0;
    acc_nxt = neg ? acc_r - term : acc_r + term;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      a_r   <= ACC_W'(a);
      b_r   <= b;
      cnt_r <= '0;
      sub_r <= ctl.sub;
      if (ctl.clear) begin
        acc_r <= '0;
      end
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      a_r   <= a_r <<< 1;
      b_r   <= b_r >> 1;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

>>> src/foc_cl_div.sv
// Bit-serial floor division of a signed value by an unsigned divisor.
module foc_cl_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [foc_cl_pkg::DIV_W-1:0] value,
  input  logic [foc_cl_pkg::DVS_W-1:0]        divisor,
  output logic signed [foc_cl_pkg::DIV_W-1:0] quot,
  output logic                                done
);
  import foc_cl_pkg::*;

  logic [DIV_W-1:0]  m_r;
  logic [DIV_W-1:0]  q_r;
  logic [DVS_W:0]    rem_r;
  logic [DVS_W+1:0]  rem_sh;
  logic [DVS_W-1:0]  dvs_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              neg_r;
  logic              busy_r;
  logic              done_r;
  logic              qbit;
  logic              last;
  logic [DIV_W-1:0]  mag;

  assign last = (cnt_r == DCNT_W'(DIV_W - 1));

  always_comb begin
    // floor for negatives: -((-v + d - 1) / d)
    mag    = value[DIV_W-1] ? DIV_W'(-value + $signed({1'b0, divisor}) - DIV_W'(1))
                            : DIV_W'(value);
    rem_sh = {rem_r, m_r[DIV_W-1]};
    qbit   = (rem_sh >= (DVS_W+2)'(dvs_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m_r   <= mag;
      dvs_r <= divisor;
      neg_r <= value[DIV_W-1];
      rem_r <= '0;
      q_r   <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= qbit ? (DVS_W+1)'(rem_sh - (DVS_W+2)'(dvs_r)) : (DVS_W+1)'(rem_sh);
      m_r   <= m_r << 1;
      q_r   <= {q_r[DIV_W-2:0], qbit};
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign quot = neg_r ? -$signed(q_r) : $signed(q_r);
  assign done = done_r;

endmodule

>>> src/foc_current_loop_top.sv
// Field-oriented PI current loop on a shared bit-serial multiplier and divider.
//
//   port group | direction | handshake           | carries
//   in_*       | input     | in_valid / in_stall | phase, bus samples, angle, request
//   out_*      | output    | out_valid/out_stall | three duties and status flags
//   cfg_*      | input     | cfg_valid/cfg_ready | register index and write data
//
// A trip or calibration item goes from idle straight to done. A run item takes
// 22 products through the serial multiplier (one coefficient bit per cycle)
// and three passes through the serial divider.
// Reset is synchronous; the config registers, offsets and loop state reload.
// The result sits in an output register, so a stalled result holds only the
// finish of the next item, not its acceptance.
module foc_current_loop_top #(
  parameter int SINE_ENTRIES = foc_cl_pkg::SINE_ENTRIES_DEF,
  parameter int PWM_MIDPOINT = foc_cl_pkg::PWM_MIDPOINT_DEF,
  parameter int ADC_BITS     = foc_cl_pkg::ADC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_phase_u_sample,
  input  logic [11:0]        in_phase_v_sample,
  input  logic [11:0]        in_phase_w_sample,
  input  logic [11:0]        in_bus_voltage_sample,
  input  logic [15:0]        in_rotor_angle,
  input  logic signed [15:0] in_current_request,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [9:0]         out_duty_u,
  output logic [9:0]         out_duty_v,
  output logic [9:0]         out_duty_w,
  output logic               out_drive_enabled,
  output logic               out_calibrating,
  output logic               out_fault,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import foc_cl_pkg::*;

  `include "foc_current_loop_top_assert.svh"

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_MUL   = 6'b000010,
    ST_MWAIT = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_DWAIT = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  typedef enum logic [4:0] {
    SP_CUR_U, SP_CUR_V, SP_CUR_W, SP_ALPHA, SP_BETA,
    SP_D_C, SP_D_S, SP_Q_C, SP_Q_S,
    SP_INT_D, SP_INT_Q, SP_VD, SP_VQ,
    SP_VA_C, SP_VA_S, SP_VB_S, SP_VB_C,
    SP_DU, SP_DV_A, SP_DV_B, SP_DW_A, SP_DW_B
  } step_t;

  typedef enum logic [1:0] {
    DS_SMOOTH_D = 2'd0,
    DS_SMOOTH_Q = 2'd1,
    DS_ANGLE    = 2'd2
  } dsel_t;

  localparam logic [11:0] ADC_MASK = 12'((17'(1) << ADC_BITS) - 17'(1));

  state_t state_r;
  step_t  step_r;
  dsel_t  dsel_r;

  logic [15:0] current_scale_r, prop_gain_r, integ_gain_r;
  logic [9:0]  integ_limit_r;
  logic [11:0] current_trip_r, voltage_trip_r, init_cycles_r;

  logic [11:0] off_r [3];
  logic [11:0] calib_cnt_r;
  logic        calib_r;
  logic        trip_r;

  logic [11:0]        raw_r [3];
  logic [15:0]        angle_r;
  logic signed [15:0] req_r;
  logic signed [15:0] cur_r [3];
  logic signed [15:0] alpha_r, beta_r, d_r, q_r;
  logic signed [15:0] sin_r, cos_r;
  logic signed [15:0] sm_r [2];
  logic signed [15:0] int_r [2];
  logic signed [18:0] vd_r, vq_r;
  logic signed [20:0] va_r, vb_r;

  logic [9:0] res_du_r, res_dv_r, res_dw_r;
  logic       res_drv_r, res_cal_r, res_flt_r;
  logic [9:0] out_du_r, out_dv_r, out_dw_r;
  logic       out_drv_r, out_cal_r, out_flt_r, out_valid_r;

  logic [11:0]        raw_m [3];
  logic [11:0]        bus_m;
  logic               trip_now;
  logic               in_acc;
  logic               out_load;
  logic [19:0]        off_sum [3];
  logic signed [12:0] diff [3];
  logic signed [17:0] a_alpha;
  logic signed [16:0] a_beta;
  logic signed [16:0] e0, e1;

  mul_ctl_t                mul_ctl;
  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic signed [ACC_W-1:0] mul_acc;
  logic                    mul_done;
  logic                    wb;

  logic                    div_start;
  logic signed [DIV_W-1:0] div_val;
  logic [DVS_W-1:0]        div_dvs;
  logic signed [DIV_W-1:0] div_quot;
  logic                    div_done;
  logic signed [15:0]      sm_src, x_src;
  logic [26:0]             ang_prod;
  logic [7:0]              p_idx;

  logic signed [ACC_W-1:0] r8, r14, r15, r19;
  logic signed [ACC_W-1:0] int_sel, int_sum, lim;
  logic signed [ACC_W-1:0] duty_full;
  logic signed [15:0]      s8, s14;

  // ---------------------------------------------------------------- ports
  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    raw_m[0] = in_phase_u_sample & ADC_MASK;
    raw_m[1] = in_phase_v_sample & ADC_MASK;
    raw_m[2] = in_phase_w_sample & ADC_MASK;
    bus_m    = in_bus_voltage_sample & ADC_MASK;
    trip_now = trip_r || (raw_m[0] > current_trip_r) || (raw_m[1] > current_trip_r) ||
               (raw_m[2] > current_trip_r) || (bus_m > voltage_trip_r);
    for (int n = 0; n < 3; n++) begin
      off_sum[n] = ({off_r[n], 8'd0} - 20'(off_r[n])) + 20'(raw_m[n]);
      diff[n]    = $signed({1'b0, raw_r[n]}) - $signed({1'b0, off_r[n]});
    end
    a_alpha = (18'(cur_r[0]) <<< 1) - 18'(cur_r[1]) - 18'(cur_r[2]);
    a_beta  = 17'(cur_r[1]) - 17'(cur_r[2]);
    e0      = 17'(sm_r[0]) + 17'(req_r);
    e1      = 17'(sm_r[1]);
  end

  // ---------------------------------------------------------------- config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      current_scale_r <= CURRENT_SCALE_RST;
      prop_gain_r     <= PROP_GAIN_RST;
      integ_gain_r    <= INTEG_GAIN_RST;
      integ_limit_r   <= INTEG_LIMIT_RST;
      current_trip_r  <= CURRENT_TRIP_RST;
      voltage_trip_r  <= VOLTAGE_TRIP_RST;
      init_cycles_r   <= INIT_CYCLES_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CURRENT_SCALE: current_scale_r <= cfg_data;
        REG_PROP_GAIN:     prop_gain_r     <= cfg_data;
        REG_INTEG_GAIN:    integ_gain_r    <= cfg_data;
        REG_INTEG_LIMIT:   integ_limit_r   <= cfg_data[9:0];
        REG_CURRENT_TRIP:  current_trip_r  <= cfg_data[11:0];
        REG_VOLTAGE_TRIP:  voltage_trip_r  <= cfg_data[11:0];
        REG_INIT_CYCLES:   init_cycles_r   <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- multiply program
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_ctl.clear = 1'b1;
    mul_ctl.sub   = 1'b0;
    wb = 1'b1;
    unique case (step_r)
      SP_CUR_U: begin mul_a = MA_W'(diff[0]); mul_b = {1'b0, current_scale_r}; end
      SP_CUR_V: begin mul_a = MA_W'(diff[1]); mul_b = {1'b0, current_scale_r}; end
      SP_CUR_W: begin mul_a = MA_W'(diff[2]); mul_b = {1'b0, current_scale_r}; end
      SP_ALPHA: begin mul_a = MA_W'(a_alpha); mul_b = K_INV_SQRT6; end
      SP_BETA:  begin mul_a = MA_W'(a_beta);  mul_b = K_INV_SQRT2; end
      SP_D_C:   begin mul_a = MA_W'(alpha_r); mul_b = MB_W'(cos_r); wb = 1'b0; end
      SP_D_S: begin
        mul_a = MA_W'(beta_r); mul_b = MB_W'(sin_r); mul_ctl.clear = 1'b0;
      end
      SP_Q_C:   begin mul_a = MA_W'(beta_r); mul_b = MB_W'(cos_r); wb = 1'b0; end
      SP_Q_S: begin
        mul_a = MA_W'(alpha_r); mul_b = MB_W'(sin_r);
        mul_ctl.clear = 1'b0; mul_ctl.sub = 1'b1;
      end
      SP_INT_D: begin mul_a = MA_W'(e0); mul_b = {1'b0, integ_gain_r}; end
      SP_INT_Q: begin mul_a = MA_W'(e1); mul_b = {1'b0, integ_gain_r}; end
      SP_VD:    begin mul_a = MA_W'(e0); mul_b = {1'b0, prop_gain_r}; end
      SP_VQ:    begin mul_a = MA_W'(e1); mul_b = {1'b0, prop_gain_r}; end
      SP_VA_C:  begin mul_a = MA_W'(vd_r); mul_b = MB_W'(cos_r); wb = 1'b0; end
      SP_VA_S: begin
        mul_a = MA_W'(vq_r); mul_b = MB_W'(sin_r);
        mul_ctl.clear = 1'b0; mul_ctl.sub = 1'b1;
      end
      SP_VB_S:  begin mul_a = MA_W'(vd_r); mul_b = MB_W'(sin_r); wb = 1'b0; end
      SP_VB_C: begin
        mul_a = MA_W'(vq_r); mul_b = MB_W'(cos_r); mul_ctl.clear = 1'b0;
      end
      SP_DU:    begin mul_a = MA_W'(va_r); mul_b = K_SQRT_2_3; end
      SP_DV_A: begin
        mul_a = MA_W'(va_r); mul_b = K_INV_SQRT6; mul_ctl.sub = 1'b1; wb = 1'b0;
      end
      SP_DV_B: begin
        mul_a = MA_W'(vb_r); mul_b = K_INV_SQRT2; mul_ctl.clear = 1'b0;
      end
      SP_DW_A: begin
        mul_a = MA_W'(va_r); mul_b = K_INV_SQRT6; mul_ctl.sub = 1'b1; wb = 1'b0;
      end
      SP_DW_B: begin
        mul_a = MA_W'(vb_r); mul_b = K_INV_SQRT2;
        mul_ctl.clear = 1'b0; mul_ctl.sub = 1'b1;
      end
      default: ;
    endcase
    mul_ctl.start = (state_r == ST_MUL);
  end

  foc_cl_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mul_ctl),
    .a     (mul_a),
    .b     (mul_b),
    .acc   (mul_acc),
    .done  (mul_done)
  );

  // ---------------------------------------------------------------- divide jobs
  always_comb begin
    ang_prod  = 27'(angle_r) * 27'(SINE_ENTRIES);
    sm_src    = (dsel_r == DS_SMOOTH_Q) ? sm_r[1] : sm_r[0];
    x_src     = (dsel_r == DS_SMOOTH_Q) ? q_r : d_r;
    div_start = (state_r == ST_DIV);
    case (dsel_r)
      DS_ANGLE: begin
        div_val = $signed(DIV_W'({ang_prod[26:16], 8'd0}));
        div_dvs = DVS_W'(SINE_ENTRIES);
      end
      default: begin
        // 2*(9s + x) + 10, then floor by 20
        div_val = (DIV_W'(sm_src) <<< 4) + (DIV_W'(sm_src) <<< 1) +
                  (DIV_W'(x_src) <<< 1) + 22'sd10;
        div_dvs = SMOOTH_DIV;
      end
    endcase
    p_idx = div_quot[7:0];
  end

  foc_cl_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .value   (div_val),
    .divisor (div_dvs),
    .quot    (div_quot),
    .done    (div_done)
  );

  // ---------------------------------------------------------------- writeback values
  always_comb begin
    r8      = rnd_sh(mul_acc, 8);
    r14     = rnd_sh(mul_acc, 14);
    r15     = rnd_sh(mul_acc, 15);
    r19     = rnd_sh(mul_acc, 19);
    s8      = sat16(r8);
    s14     = sat16(r14);
    int_sel = (step_r == SP_INT_Q || step_r == SP_VQ) ? ACC_W'(int_r[1]) : ACC_W'(int_r[0]);
    lim     = $signed(ACC_W'({integ_limit_r, 5'd0}));
    int_sum = clamp40(int_sel + r15, -lim, lim);
    duty_full = clamp40(ACC_W'(PWM_MIDPOINT) + r19, '0, 40'sd1023);
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SP_CUR_U;
      dsel_r      <= DS_SMOOTH_D;
      calib_r     <= 1'b1;
      calib_cnt_r <= '0;
      trip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            step_r <= SP_CUR_U;
            dsel_r <= DS_SMOOTH_D;
            if (trip_now) begin
              trip_r  <= 1'b1;
              state_r <= ST_DONE;
            end else if (calib_r) begin
              if (calib_cnt_r >= init_cycles_r) begin
                calib_r <= 1'b0;
              end else begin
                calib_cnt_r <= calib_cnt_r + 1'b1;
              end
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: state_r <= ST_MWAIT;
        ST_MWAIT: begin
          if (mul_done) begin
            step_r <= step_t'(step_r + 1'b1);
            if (step_r == SP_DW_B) begin
              state_r <= ST_DONE;
            end else if (step_r == SP_Q_S) begin
              state_r <= ST_DIV;
            end else begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_DIV: state_r <= ST_DWAIT;
        ST_DWAIT: begin
          if (div_done) begin
            if (dsel_r == DS_ANGLE) begin
              state_r <= ST_MUL;
            end else begin
              dsel_r  <= (dsel_r == DS_SMOOTH_D) ? DS_SMOOTH_Q : DS_ANGLE;
              state_r <= ST_DIV;
            end
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int n = 0; n < 3; n++) begin
        off_r[n] <= ADC_OFFSET_RST;
      end
      sin_r    <= '0;
      cos_r    <= '0;
      sm_r[0]  <= '0;
      sm_r[1]  <= '0;
      int_r[0] <= '0;
      int_r[1] <= '0;
    end else begin
      if (in_acc && !trip_now && calib_r) begin
        for (int n = 0; n < 3; n++) begin
          off_r[n] <= off_sum[n][19:8];
        end
      end
      if (state_r == ST_MWAIT && mul_done) begin
        case (step_r)
          SP_INT_D: int_r[0] <= int_sum[15:0];
          SP_INT_Q: int_r[1] <= int_sum[15:0];
          default: ;
        endcase
      end
      if (state_r == ST_DWAIT && div_done) begin
        case (dsel_r)
          DS_SMOOTH_D: sm_r[0] <= sat16(ACC_W'(div_quot));
          DS_SMOOTH_Q: sm_r[1] <= sat16(ACC_W'(div_quot));
          default: begin
            // refresh sine and cosine after Park has used the old pair
            sin_r <= sine_lut(p_idx);
            cos_r <= sine_lut(p_idx + 8'd64);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int n = 0; n < 3; n++) begin
        raw_r[n] <= raw_m[n];
      end
      angle_r   <= in_rotor_angle;
      req_r     <= in_current_request;
      res_du_r  <= '0;
      res_dv_r  <= '0;
      res_dw_r  <= '0;
      res_flt_r <= trip_now;
      res_cal_r <= !trip_now && calib_r;
      res_drv_r <= !trip_now && !calib_r;
    end
    if (state_r == ST_MWAIT && mul_done && wb) begin
      case (step_r)
        SP_CUR_U: cur_r[0] <= s8;
        SP_CUR_V: cur_r[1] <= s8;
        SP_CUR_W: cur_r[2] <= s8;
        SP_ALPHA: alpha_r  <= s14;
        SP_BETA:  beta_r   <= s14;
        SP_D_S:   d_r      <= s14;
        SP_Q_S:   q_r      <= s14;
        SP_VD:    vd_r     <= 19'(r15 + int_sel);
        SP_VQ:    vq_r     <= 19'(r15 + int_sel);
        SP_VA_S:  va_r     <= r14[20:0];
        SP_VB_C:  vb_r     <= r14[20:0];
        SP_DU:    res_du_r <= duty_full[9:0];
        SP_DV_B:  res_dv_r <= duty_full[9:0];
        SP_DW_B:  res_dw_r <= duty_full[9:0];
        default: ;
      endcase
    end
    if (out_load) begin
      out_du_r  <= res_du_r;
      out_dv_r  <= res_dv_r;
      out_dw_r  <= res_dw_r;
      out_drv_r <= res_drv_r;
      out_cal_r <= res_cal_r;
      out_flt_r <= res_flt_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_duty_u        = out_du_r;
  assign out_duty_v        = out_dv_r;
  assign out_duty_w        = out_dw_r;
  assign out_drive_enabled = out_drv_r;
  assign out_calibrating   = out_cal_r;
  assign out_fault         = out_flt_r;

  // ---------------------------------------------------------------- checks
  `FOC_ASSERT_NEXT(a_trip_sticky, trip_r, trip_r)
  `FOC_ASSERT_IMP(a_fault_off, out_valid && out_fault, !out_drive_enabled && out_duty_u == 10'd0)
  `FOC_ASSERT_IMP(a_calib_end, $fell(calib_r), !$past(trip_r) && trip_r == $past(trip_now))
  `FOC_ASSERT_IMP(a_run_no_calib, state_r == ST_MUL, !calib_r && !trip_r)

endmodule

>>> dv/tb_top.sv
// Self-checking testbench for the field-oriented PI current loop top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import foc_cl_pkg::*;

  localparam longint CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [11:0] ph_u, ph_v, ph_w, bus;
    logic [15:0] angle;
    logic signed [15:0] req;
  } sample_set_t;

  typedef struct {
    logic [9:0] duty_u, duty_v, duty_w;
    logic drive_en, calib, fault;
  } pwm_cmd_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_stall;
  logic [11:0] in_ph_u = '0, in_ph_v = '0, in_ph_w = '0, in_bus = '0;
  logic [15:0] in_angle = '0;
  logic signed [15:0] in_req = '0;
  logic out_valid, out_stall = 1'b0;
  logic [9:0] out_duty_u, out_duty_v, out_duty_w;
  logic out_drive_enabled, out_calibrating, out_fault;
  logic cfg_valid = 1'b0, cfg_ready;
  reg_idx_t cfg_index = REG_CURRENT_SCALE;
  logic [15:0] cfg_data = '0;

  always #5 clk = ~clk;

  foc_current_loop_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_phase_u_sample(in_ph_u), .in_phase_v_sample(in_ph_v),
    .in_phase_w_sample(in_ph_w), .in_bus_voltage_sample(in_bus),
    .in_rotor_angle(in_angle), .in_current_request(in_req),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_duty_u(out_duty_u), .out_duty_v(out_duty_v), .out_duty_w(out_duty_w),
    .out_drive_enabled(out_drive_enabled), .out_calibrating(out_calibrating),
    .out_fault(out_fault),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // loop model: registers and state
  longint scale_r, pgain_r, igain_r, ilim_r, itrip_r, vtrip_r, init_r;
  longint offs[3];
  bit cal_on, tripped;
  longint cal_cnt, sin_v, cos_v;
  longint filt_dq[2], integ_dq[2];

  pwm_cmd_t cmd_q[$];
  int send_gap_pct = 0, stall_pct = 0;
  int mismatches = 0, n_sent = 0, n_checked = 0, n_run = 0, n_cal = 0, n_fault = 0;
  longint cycles = 0;

  function automatic longint round_sh(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat_q(longint v);
    return clip(v, -32768, 32767);
  endfunction

  function automatic longint sine_of(int p);
    int r;
    r = p & 63;
    case ((p >> 6) & 3)
      0: return longint'(QSINE[r]);
      1: return longint'(QSINE[64 - r]);
      2: return -longint'(QSINE[r]);
      default: return -longint'(QSINE[64 - r]);
    endcase
  endfunction

  function automatic longint filter_step(longint s, longint x);
    longint v;
    v = 2 * (9 * s + x) + 10;
    return sat_q(v >= 0 ? v / 20 : -((-v + 19) / 20));
  endfunction

  function automatic longint duty_from(longint v);
    return clip(512 + round_sh(v, 19), 0, 1023);
  endfunction

  function automatic pwm_cmd_t predict_pwm(sample_set_t s);
    pwm_cmd_t r;
    longint raw[3], cur[3], alpha, beta, d, q, e[2], lim, vd, vq, va, vb;
    int p;
    raw[0] = s.ph_u; raw[1] = s.ph_v; raw[2] = s.ph_w;
    r = '{default: 0};
    if (raw[0] > itrip_r || raw[1] > itrip_r || raw[2] > itrip_r || s.bus > vtrip_r)
      tripped = 1'b1;
    if (tripped) begin
      r.fault = 1'b1;
      return r;
    end
    if (cal_on) begin
      for (int n = 0; n < 3; n++) offs[n] = (255 * offs[n] + raw[n]) / 256;
      if (cal_cnt >= init_r) cal_on = 1'b0;
      else cal_cnt = (cal_cnt + 1) & 12'hfff;
      r.calib = 1'b1;
      return r;
    end
    for (int n = 0; n < 3; n++) cur[n] = sat_q(round_sh((raw[n] - offs[n]) * scale_r, 8));
    alpha = sat_q(round_sh((2 * cur[0] - cur[1] - cur[2]) * longint'(K_INV_SQRT6), 14));
    beta = sat_q(round_sh((cur[1] - cur[2]) * longint'(K_INV_SQRT2), 14));
    // Park on the angle of the previous sample set
    d = sat_q(round_sh(cos_v * alpha + sin_v * beta, 14));
    q = sat_q(round_sh(cos_v * beta - sin_v * alpha, 14));
    p = s.angle >> 8;
    sin_v = sine_of(p);
    cos_v = sine_of((p + 64) & 255);
    filt_dq[0] = filter_step(filt_dq[0], d);
    filt_dq[1] = filter_step(filt_dq[1], q);
    e[0] = filt_dq[0] + longint'(s.req);
    e[1] = filt_dq[1];
    lim = ilim_r * 32;
    for (int n = 0; n < 2; n++)
      integ_dq[n] = clip(integ_dq[n] + round_sh(e[n] * igain_r, 15), -lim, lim);
    vd = round_sh(e[0] * pgain_r, 15) + integ_dq[0];
    vq = round_sh(e[1] * pgain_r, 15) + integ_dq[1];
    va = round_sh(cos_v * vd - sin_v * vq, 14);
    vb = round_sh(sin_v * vd + cos_v * vq, 14);
    r.duty_u = 10'(duty_from(va * longint'(K_SQRT_2_3)));
    r.duty_v = 10'(duty_from(-va * longint'(K_INV_SQRT6) + vb * longint'(K_INV_SQRT2)));
    r.duty_w = 10'(duty_from(-va * longint'(K_INV_SQRT6) - vb * longint'(K_INV_SQRT2)));
    r.drive_en = 1'b1;
    return r;
  endfunction

  task automatic send_samples(sample_set_t s);
    pwm_cmd_t exp_cmd;
    if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_ph_u <= s.ph_u; in_ph_v <= s.ph_v; in_ph_w <= s.ph_w; in_bus <= s.bus;
    in_angle <= s.angle; in_req <= s.req;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    exp_cmd = predict_pwm(s);
    cmd_q.push_back(exp_cmd);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, longint val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(val);
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CURRENT_SCALE: scale_r = val & 16'hffff;
      REG_PROP_GAIN: pgain_r = val & 16'hffff;
      REG_INTEG_GAIN: igain_r = val & 16'hffff;
      REG_INTEG_LIMIT: ilim_r = val & 10'h3ff;
      REG_CURRENT_TRIP: itrip_r = val & 12'hfff;
      REG_VOLTAGE_TRIP: vtrip_r = val & 12'hfff;
      REG_INIT_CYCLES: init_r = val & 12'hfff;
      default: ;
    endcase
  endtask

  function automatic sample_set_t make_samples(int u, int v, int w, int bus, int ang, int rq);
    sample_set_t s;
    s.ph_u = 12'(u); s.ph_v = 12'(v); s.ph_w = 12'(w); s.bus = 12'(bus);
    s.angle = 16'(ang); s.req = 16'(rq);
    return s;
  endfunction

  function automatic int near_offset(int n, int span);
    return int'(clip(offs[n] + $signed($urandom_range(2 * span)) - span, 0, 4095));
  endfunction

  function automatic sample_set_t random_samples();
    sample_set_t s;
    int span;
    span = ($urandom_range(3) == 0) ? 400 : 40;
    if ($urandom_range(9) < 7) begin
      s = make_samples(near_offset(0, span), near_offset(1, span), near_offset(2, span),
                       $urandom_range(4095), $urandom_range(65535),
                       $signed($urandom_range(4096)) - 2048);
    end else begin
      s = make_samples($urandom_range(4095), $urandom_range(4095), $urandom_range(4095),
                       $urandom_range(4095), $urandom_range(65535), $urandom_range(65535));
    end
    return s;
  endfunction

  task automatic test_calibration();
    write_reg(REG_INIT_CYCLES, 8);
    repeat (3) send_samples(make_samples(1700, 2100, 4095, 0, 0, 0));
    // lower the count below the progress: calibration ends on the next request
    write_reg(REG_INIT_CYCLES, 1);
    send_samples(make_samples(0, 4095, 1900, 4095, 0, 0));
    send_samples(make_samples(1900, 1900, 1900, 100, 0, 0));
    n_cal += 4;
    n_run += 1;
  endtask

  task automatic test_directed_run();
    send_samples(make_samples(0, 4095, 0, 0, 0, 32767));
    send_samples(make_samples(4095, 0, 4095, 4095, 16'hffff, -32768));
    send_samples(make_samples(4095, 4095, 4095, 2000, 16'h4000, -32768));
    send_samples(make_samples(0, 0, 0, 2000, 16'h8000, 32767));
    send_samples(make_samples(1900, 1900, 1900, 2000, 16'hc000, 0));
    send_samples(make_samples(2400, 1600, 1700, 2000, 16'h00ff, -32768));
    send_samples(make_samples(1400, 2300, 2000, 2000, 16'h7f00, 1024));
    send_samples(make_samples(2048, 2047, 1, 2000, 16'haaaa, 16'h5555));
    drain();
    n_run += 8;
  endtask

  task automatic test_random_run(int count, int gap, int stall);
    send_gap_pct = gap;
    stall_pct = stall;
    for (int k = 0; k < count; k++) begin
      send_samples(random_samples());
      // mix in stretches without idling
      if (k % 50 == 25) begin
        send_gap_pct = 0;
        stall_pct = 0;
      end else if (k % 50 == 40) begin
        send_gap_pct = gap;
        stall_pct = stall;
      end
    end
    n_run += count;
    drain();
  endtask

  task automatic test_gain_settings();
    write_reg(REG_CURRENT_SCALE, 65535);
    write_reg(REG_PROP_GAIN, 65535);
    write_reg(REG_INTEG_GAIN, 65535);
    write_reg(REG_INTEG_LIMIT, 1023);
    test_random_run(150, 66, 16);
    write_reg(REG_CURRENT_SCALE, 0);
    write_reg(REG_PROP_GAIN, 0);
    write_reg(REG_INTEG_GAIN, 0);
    write_reg(REG_INTEG_LIMIT, 0);
    write_reg(REG_INIT_CYCLES, 4095);
    test_random_run(100, 66, 16);
    write_reg(REG_CURRENT_SCALE, $urandom_range(2000, 100));
    write_reg(REG_PROP_GAIN, $urandom_range(65535));
    write_reg(REG_INTEG_GAIN, $urandom_range(8000));
    write_reg(REG_INTEG_LIMIT, $urandom_range(1023));
    write_reg(REG_INIT_CYCLES, 0);
    test_random_run(200, 0, 0);
  endtask

  task automatic test_trip();
    write_reg(REG_CURRENT_TRIP, 4095);
    write_reg(REG_VOLTAGE_TRIP, 3000);
    send_samples(make_samples(1900, 1900, 1900, 3000, 0, 0));
    send_samples(make_samples(1900, 1900, 1900, 3001, 0, 0));
    drain();
    write_reg(REG_CURRENT_TRIP, 0);
    write_reg(REG_VOLTAGE_TRIP, 0);
    for (int k = 0; k < 6; k++) send_samples(random_samples());
    n_fault += 7;
    n_run += 1;
    drain();
  endtask

  always @(posedge clk) begin
    out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    pwm_cmd_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (cmd_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected PWM command at cycle %0d", cycles);
      end else begin
        e = cmd_q.pop_front();
        n_checked++;
        if (e.duty_u !== out_duty_u || e.duty_v !== out_duty_v || e.duty_w !== out_duty_w ||
            e.drive_en !== out_drive_enabled || e.calib !== out_calibrating ||
            e.fault !== out_fault) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d exp %0d/%0d/%0d %b%b%b got %0d/%0d/%0d %b%b%b",
                     n_checked, e.duty_u, e.duty_v, e.duty_w, e.drive_en, e.calib, e.fault,
                     out_duty_u, out_duty_v, out_duty_w, out_drive_enabled,
                     out_calibrating, out_fault);
        end
      end
    end
  end

  initial begin
    scale_r = CURRENT_SCALE_RST; pgain_r = PROP_GAIN_RST; igain_r = INTEG_GAIN_RST;
    ilim_r = INTEG_LIMIT_RST; itrip_r = CURRENT_TRIP_RST; vtrip_r = VOLTAGE_TRIP_RST;
    init_r = INIT_CYCLES_RST;
    for (int n = 0; n < 3; n++) offs[n] = ADC_OFFSET_RST;
    cal_on = 1'b1; tripped = 1'b0; cal_cnt = 0; sin_v = 0; cos_v = 0;
    filt_dq = '{0, 0}; integ_dq = '{0, 0};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_calibration();
    test_directed_run();
    // defaults first, mostly receiver stalls then mostly sender gaps
    test_random_run(150, 16, 66);
    test_random_run(150, 66, 16);
    test_gain_settings();
    test_random_run(150, 0, 0);
    test_trip();
    drain();
    $display("covered %0d requests: %0d calibration, %0d run, %0d after a trip",
             n_sent, n_cal, n_run, n_fault);
    $display("gain and limit extremes, lowered calibration count, bus trip latch; %0d mismatches",
             mismatches);
    if (mismatches == 0 && cmd_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
